// File: rtl/cdad_pkg.sv
// Shared types, codes and calendar helper functions for the date adder.
package cdad_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DomW = 5;
  localparam int unsigned OffW = 17;
  localparam int unsigned DayW = 18;
  localparam int unsigned CycW = 9;

  localparam logic [YearW-1:0] TopYear = 14'd9999;
  localparam logic [MonthW-1:0] LastMonth = 4'd12;
  localparam logic [MonthW-1:0] FirstMonth = 4'd1;
  localparam logic [CycW-1:0] CycLast = 9'd399;
  localparam logic [YearW-1:0] CycLen = 14'd400;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_SAT      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  // Working date: day is signed and may lie far outside the month.
  typedef struct packed {
    logic [YearW-1:0]        year;
    logic [MonthW-1:0]       month;
    logic signed [DayW-1:0]  day;
    logic [CycW-1:0]         cyc;   // year modulo 400
  } walk_t;

  typedef struct packed {
    walk_t nxt;
    logic  fin;   // day already within the month
    logic  sat;   // walk ran past an end of the year range
  } step_t;

  function automatic logic is_leap(input logic [1:0] year_lo, input logic [CycW-1:0] cyc);
    logic century;
    century = (cyc == 9'd0) || (cyc == 9'd100) || (cyc == 9'd200) || (cyc == 9'd300);
    return (year_lo == 2'd0) && (!century || (cyc == 9'd0));
  endfunction

  function automatic logic [DomW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DomW-1:0] len;
    unique case (month) inside
      4'd2:                                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                                 len = 5'd31;
      default:                               len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/cdad_step_unit.sv
// One month step of the date walk: month length, compare and the shared day adder.
module cdad_step_unit (
  input  cdad_pkg::walk_t                   cur_i,
  input  logic [cdad_pkg::YearW-1:0]        min_year_i,
  output cdad_pkg::step_t                   step_o
);

  logic                               leap;
  logic [cdad_pkg::DomW-1:0]          len_cur;
  logic [cdad_pkg::DomW-1:0]          len_prev;
  logic signed [cdad_pkg::DayW-1:0]   len_cur_s;
  logic signed [cdad_pkg::DayW-1:0]   addend;
  logic signed [cdad_pkg::DayW-1:0]   day_sum;
  logic                               fwd;
  logic                               bwd;
  logic [cdad_pkg::MonthW-1:0]        month_dn;

  assign leap      = cdad_pkg::is_leap(cur_i.year[1:0], cur_i.cyc);
  assign len_cur   = cdad_pkg::month_len(cur_i.month, leap);
  assign len_cur_s = $signed({{(cdad_pkg::DayW-cdad_pkg::DomW){1'b0}}, len_cur});
  assign fwd       = cur_i.day > len_cur_s;
  assign bwd       = cur_i.day < $signed(18'sd1);

  // Stepping back across a year end always lands in December, whose length
  // does not depend on the leap rule, so the current year's flag serves.
  assign month_dn = (cur_i.month <= cdad_pkg::FirstMonth) ? cdad_pkg::LastMonth
                                                           : cur_i.month - 4'd1;
  assign len_prev = cdad_pkg::month_len(month_dn, leap);

  assign addend  = fwd ? -len_cur_s
                       : $signed({{(cdad_pkg::DayW-cdad_pkg::DomW){1'b0}}, len_prev});
  assign day_sum = cur_i.day + addend;

  always_comb begin
    step_o.nxt = cur_i;
    step_o.fin = !fwd && !bwd;
    step_o.sat = 1'b0;
    if (fwd) begin
      step_o.nxt.day = day_sum;
      if (cur_i.month >= cdad_pkg::LastMonth) begin
        if (cur_i.year >= cdad_pkg::TopYear) begin
          step_o.sat       = 1'b1;
          step_o.nxt.year  = cdad_pkg::TopYear;
          step_o.nxt.month = cdad_pkg::LastMonth;
          step_o.nxt.day   = 18'sd31;
        end else begin
          step_o.nxt.month = cdad_pkg::FirstMonth;
          step_o.nxt.year  = cur_i.year + 14'd1;
          step_o.nxt.cyc   = (cur_i.cyc == cdad_pkg::CycLast) ? 9'd0 : cur_i.cyc + 9'd1;
        end
      end else begin
        step_o.nxt.month = cur_i.month + 4'd1;
      end
    end else if (bwd) begin
      step_o.nxt.day   = day_sum;
      step_o.nxt.month = month_dn;
      if (cur_i.month <= cdad_pkg::FirstMonth) begin
        if (cur_i.year <= min_year_i) begin
          step_o.sat       = 1'b1;
          step_o.nxt.year  = min_year_i;
          step_o.nxt.month = cdad_pkg::FirstMonth;
          step_o.nxt.day   = 18'sd1;
        end else begin
          step_o.nxt.year = cur_i.year - 14'd1;
          step_o.nxt.cyc  = (cur_i.cyc == 9'd0) ? cdad_pkg::CycLast : cur_i.cyc - 9'd1;
        end
      end
    end
  end

endmodule

// File: rtl/calendar_date_add_days.sv
// Top level of the Gregorian date adder: stream ports, sequencer and result register.
//
// Adds a signed day offset to a Gregorian date, one word at a time. A word is
// taken only while the sequencer is idle; it then reduces the start year
// modulo 400 by repeated subtraction, checks the date, and walks the day
// count one month per cycle through the shared step unit, which carries or
// borrows a whole month length each time. The result sits in an output
// register, so a new word is accepted while the previous result still waits
// on the master side.
// Status 1 marks an invalid start date (year outside MIN_YEAR..9999, month
// outside 1..12 or day outside the month) and gives zero date fields; status
// 2 marks a walk that ran past 9999-12-31 or before MIN_YEAR-01-01, in which
// case the date saturates to that end.
module calendar_date_add_days #(
  parameter int unsigned MIN_YEAR = 1900
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], day_offset[39:23]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18], status[24:23], zeros
  output logic [31:0] m_axis_tdata
);

  localparam logic [cdad_pkg::YearW-1:0] MinYearC = cdad_pkg::YearW'(MIN_YEAR);

  cdad_pkg::state_e state_q, state_d;

  cdad_pkg::walk_t                  walk_q, walk_d;
  logic [cdad_pkg::YearW-1:0]       rem_q, rem_d;
  logic [cdad_pkg::DomW-1:0]        dom_q, dom_d;
  logic [cdad_pkg::OffW-1:0]        off_q, off_d;
  cdad_pkg::status_e                stat_q, stat_d;

  logic                             out_vld_q, out_vld_d;
  logic [cdad_pkg::YearW-1:0]       res_year_q, res_year_d;
  logic [cdad_pkg::MonthW-1:0]      res_month_q, res_month_d;
  logic [cdad_pkg::DomW-1:0]        res_day_q, res_day_d;
  cdad_pkg::status_e                res_stat_q, res_stat_d;

  cdad_pkg::step_t                  step;
  logic                             in_take;
  logic                             out_free;
  logic                             mod_done;
  logic                             date_bad;
  logic [cdad_pkg::DomW-1:0]        start_len;

  cdad_step_unit u_step (
    .cur_i      (walk_q),
    .min_year_i (MinYearC),
    .step_o     (step)
  );

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign mod_done = rem_q < cdad_pkg::CycLen;

  // Once the remainder is known the leap rule, and with it the month length,
  // can be applied to the start date.
  assign start_len = cdad_pkg::month_len(walk_q.month,
                                         cdad_pkg::is_leap(walk_q.year[1:0], rem_q[8:0]));
  assign date_bad  = (walk_q.year < MinYearC) || (walk_q.year > cdad_pkg::TopYear) ||
                     (dom_q == 5'd0) || (dom_q > start_len);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdad_pkg::ST_IDLE:  if (in_take) state_d = cdad_pkg::ST_MOD;
      cdad_pkg::ST_MOD:   if (mod_done) state_d = cdad_pkg::ST_CHECK;
      cdad_pkg::ST_CHECK: state_d = date_bad ? cdad_pkg::ST_DONE : cdad_pkg::ST_WALK;
      cdad_pkg::ST_WALK:  if (step.fin || step.sat) state_d = cdad_pkg::ST_DONE;
      cdad_pkg::ST_DONE:  if (out_free) state_d = cdad_pkg::ST_IDLE;
      default:            state_d = cdad_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates.
  always_comb begin
    s_axis_tready = 1'b0;
    walk_d        = walk_q;
    rem_d         = rem_q;
    dom_d         = dom_q;
    off_d         = off_q;
    stat_d        = stat_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    res_year_d    = res_year_q;
    res_month_d   = res_month_q;
    res_day_d     = res_day_q;
    res_stat_d    = res_stat_q;
    unique case (state_q)
      cdad_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        walk_d.year   = s_axis_tdata[13:0];
        walk_d.month  = s_axis_tdata[17:14];
        dom_d         = s_axis_tdata[22:18];
        off_d         = s_axis_tdata[39:23];
        rem_d         = s_axis_tdata[13:0];
        stat_d        = cdad_pkg::STAT_OK;
      end
      cdad_pkg::ST_MOD: begin
        if (!mod_done) begin
          rem_d = rem_q - cdad_pkg::CycLen;
        end
      end
      cdad_pkg::ST_CHECK: begin
        walk_d.cyc = rem_q[8:0];
        walk_d.day = $signed({{(cdad_pkg::DayW-cdad_pkg::DomW){1'b0}}, dom_q}) +
                     $signed({off_q[cdad_pkg::OffW-1], off_q});
        if (date_bad) begin
          stat_d = cdad_pkg::STAT_BAD_DATE;
        end
      end
      cdad_pkg::ST_WALK: begin
        walk_d = step.nxt;
        if (step.sat) begin
          stat_d = cdad_pkg::STAT_SAT;
        end
      end
      cdad_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          res_stat_d = stat_q;
          if (stat_q == cdad_pkg::STAT_BAD_DATE) begin
            res_year_d  = '0;
            res_month_d = '0;
            res_day_d   = '0;
          end else begin
            res_year_d  = walk_q.year;
            res_month_d = walk_q.month;
            res_day_d   = walk_q.day[cdad_pkg::DomW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cdad_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q      <= walk_d;
    rem_q       <= rem_d;
    dom_q       <= dom_d;
    off_q       <= off_d;
    stat_q      <= stat_d;
    res_year_q  <= res_year_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_stat_q  <= res_stat_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, res_stat_q, res_day_q, res_month_q, res_year_q};

endmodule
